FILE: rtl/rational_arith_reduce_macros.svh
// assertion macros shared by the rational arithmetic block
// expects clk and arst_n in the scope of each use
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH

// condition that holds at every clock edge out of reset
`define RAR_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define RAR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RAR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rar_pkg.sv
// shared types and constants of the rational arithmetic block
// no dependencies
package rar_pkg;

	typedef logic [1:0] kind_t;

	// operation codes carried in the input tuser
	localparam kind_t KIND_ADD = 2'd0;
	localparam kind_t KIND_SUB = 2'd1;
	localparam kind_t KIND_MUL = 2'd2;
	localparam kind_t KIND_DIV = 2'd3;

	// result field widths
	localparam int NUM_W       = 33;
	localparam int DEN_W       = 31;
	localparam int OUT_TDATA_W = 64;

	// status of the reduction unit towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} rar_red_stat_t;

endpackage

FILE: rtl/rar_mul.sv
// registered unsigned multiplier shared by all product steps
// depends on nothing but its width parameter
module rar_mul #(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p_q
);

	// one product per cycle, result registered
	always_ff @(posedge clk) begin
		p_q <= (2*W)'(a) * (2*W)'(b);
	end

endmodule

FILE: rtl/rar_sub.sv
// shared subtract and compare unit of the reduction datapath
// depends on nothing but its width parameter
module rar_sub #(
	parameter int W = 33
) (
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	output logic [W-1:0] diff,
	output logic         borrow
);

	// difference and borrow, borrow set when y exceeds x
	always_comb begin
		{borrow, diff} = {1'b0, x} - {1'b0, y};
	end

endmodule

FILE: rtl/rar_reduce.sv
// reduction to lowest terms: binary gcd, then two restoring divisions
// depends on rar_pkg, rar_sub and the assertion macro header
`include "rational_arith_reduce_macros.svh"

module rar_reduce #(
	parameter int PW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PW-1:0]         num_in,
	input  logic [PW-1:0]         den_in,
	output logic [PW-1:0]         num_out,
	output logic [PW-1:0]         den_out,
	output rar_pkg::rar_red_stat_t stat
);

	localparam int CW = $clog2(PW);

	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_GCD  = 2'd1;
	localparam logic [1:0] R_DIVN = 2'd2;
	localparam logic [1:0] R_DIVD = 2'd3;

	logic [1:0]    st_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	// a_q and b_q hold the gcd pair, later divisor and remainder
	logic [PW-1:0] a_q;
	logic [PW-1:0] b_q;
	logic [PW-1:0] n_q;
	logic [PW-1:0] d_q;

	logic [PW:0]   sub_x;
	logic [PW:0]   sub_y;
	logic [PW:0]   sub_d;
	logic          sub_b;
	logic [PW:0]   neg_d;
	logic          qbit;

	// operand selection for the shared subtractor
	always_comb begin
		case (st_q)
			R_DIVN: begin
				sub_x = {b_q, n_q[PW-1]};
				sub_y = {1'b0, a_q};
			end
			R_DIVD: begin
				sub_x = {b_q, d_q[PW-1]};
				sub_y = {1'b0, a_q};
			end
			default: begin
				sub_x = {1'b0, a_q};
				sub_y = {1'b0, b_q};
			end
		endcase
	end

	rar_sub #(.W(PW + 1)) u_sub (
		.x      (sub_x),
		.y      (sub_y),
		.diff   (sub_d),
		.borrow (sub_b)
	);

	assign neg_d = (PW + 1)'(0) - sub_d;
	assign qbit  = !sub_b;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= R_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == R_DIVD) && (cnt_q == '0);
			unique case (st_q)
				R_IDLE: begin
					if (start) begin
						st_q <= R_GCD;
					end
				end
				R_GCD: begin
					if (a_q == '0 || b_q == '0) begin
						cnt_q <= CW'(PW - 1);
						st_q  <= R_DIVN;
					end
				end
				R_DIVN: begin
					if (cnt_q == '0) begin
						cnt_q <= CW'(PW - 1);
						st_q  <= R_DIVD;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				R_DIVD: begin
					if (cnt_q == '0) begin
						st_q <= R_IDLE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: st_q <= R_IDLE;
			endcase
		end
	end

	// datapath: shared factors of two leave n and d as they leave a and b
	always_ff @(posedge clk) begin
		case (st_q)
			R_IDLE: begin
				if (start) begin
					a_q <= num_in;
					b_q <= den_in;
					n_q <= num_in;
					d_q <= den_in;
				end
			end
			R_GCD: begin
				if (a_q == '0 || b_q == '0) begin
					a_q <= a_q | b_q;
					b_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					n_q <= n_q >> 1;
					d_q <= d_q >> 1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (!sub_b) begin
					// both odd: difference is even, halve it at once
					a_q <= {1'b0, sub_d[PW-1:1]};
				end else begin
					b_q <= {1'b0, neg_d[PW-1:1]};
				end
			end
			R_DIVN: begin
				// remainder starts from zero again for the denominator
				if (cnt_q == '0) begin
					b_q <= '0;
				end else begin
					b_q <= qbit ? sub_d[PW-1:0] : sub_x[PW-1:0];
				end
				n_q <= {n_q[PW-2:0], qbit};
			end
			R_DIVD: begin
				b_q <= qbit ? sub_d[PW-1:0] : sub_x[PW-1:0];
				d_q <= {d_q[PW-2:0], qbit};
			end
			default: begin
			end
		endcase
	end

	assign num_out   = n_q;
	assign den_out   = d_q;
	assign stat.busy = (st_q != R_IDLE);
	assign stat.done = done_q;

	`RAR_ASSERT_IMP(a_start_idle, start, st_q == R_IDLE, "reduce started while busy")
	`RAR_ASSERT_IMP(a_gcd_nonzero, st_q == R_GCD, a_q != '0 || b_q != '0, "gcd pair is all zero")
	`RAR_ASSERT_IMP(a_div_odd, st_q == R_DIVN || st_q == R_DIVD, a_q[0], "divisor not odd")

endmodule

FILE: rtl/rational_arith_reduce.sv
// top level of the rational arithmetic block: input capture, products, sum, output
// depends on rar_pkg, rar_mul, rar_reduce and the assertion macro header
`include "rational_arith_reduce_macros.svh"

// Takes two fractions and an operation (add, subtract, multiply, divide),
// forms the exact result by cross-multiplication and gives it in lowest
// terms with a positive denominator. One item is in work at a time: the
// input is not ready from acceptance until its result has been taken.
// An item takes three products on a single shared multiplier, a state
// that forms the numerator and denominator, then the reduction unit:
// a binary gcd of at most about 2*P steps followed by two restoring
// divisions of P steps each on one shared subtractor, with
// P = 2*OPERAND_WIDTH, and a final load of the result. A zero numerator
// skips the reduction, and a zero denominator goes straight to the
// output, which is offered in the cycle after acceptance.
// A zero denominator, in an input or from dividing by zero, gives 0 over 0
// with the error flag set.
module rational_arith_reduce #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// left_num, left_den, right_num, right_den from the lowest bit up
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	// kind
	input  logic [1:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// result_num, result_den from the lowest bit up
	output logic [rar_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// zero_den_error
	output logic                                 m_tuser
);

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int EW = (PW > rar_pkg::NUM_W) ? PW : rar_pkg::NUM_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_M1   = 3'd1;
	localparam logic [2:0] S_M2   = 3'd2;
	localparam logic [2:0] S_M3   = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_RED  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;

	// captured operands in sign and magnitude
	rar_pkg::kind_t kind_q;
	logic [W-1:0] ln_q, ld_q, rn_q, rd_q;
	logic         ln_n_q, ld_n_q, rn_n_q, rd_n_q;

	logic [W-1:0] ln_raw, ld_raw, rn_raw, rd_raw;
	logic         in_err;

	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] mul_p;
	logic [PW-1:0] p1_q, p2_q;

	logic          s1_raw, s2_raw, a_neg, b_neg;
	logic [PW-1:0] sum_ab;
	logic [PW:0]   d_ab, d_ba;
	logic [PW-1:0] add_mag;
	logic          add_neg;
	logic [PW-1:0] num_mag, den_mag;
	logic          num_neg, den_neg;
	logic          neg_q;

	logic                    red_start;
	logic [PW-1:0]           red_num, red_den;
	rar_pkg::rar_red_stat_t  red_stat;

	logic [EW-1:0]                   nmag_ext, nval_ext, dmag_ext;
	logic [rar_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                            m_tuser_q;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? W'(~v + W'(1)) : v;
	endfunction

	assign ln_raw = s_tdata[W-1:0];
	assign ld_raw = s_tdata[2*W-1:W];
	assign rn_raw = s_tdata[3*W-1:2*W];
	assign rd_raw = s_tdata[4*W-1:3*W];

	// zero denominator in an input, or division by a zero fraction
	assign in_err = (ld_raw == '0) || (rd_raw == '0)
		|| (s_tuser == rar_pkg::KIND_DIV && rn_raw == '0);

	// multiplier operands for each product step
	always_comb begin
		case (state_q)
			S_M1: begin
				mul_a = ln_q;
				mul_b = (kind_q == rar_pkg::KIND_MUL) ? rn_q : rd_q;
			end
			S_M2: begin
				case (kind_q) inside
					rar_pkg::KIND_ADD, rar_pkg::KIND_SUB: begin
						mul_a = rn_q;
						mul_b = ld_q;
					end
					rar_pkg::KIND_MUL: begin
						mul_a = ld_q;
						mul_b = rd_q;
					end
					default: begin
						mul_a = ld_q;
						mul_b = rn_q;
					end
				endcase
			end
			default: begin
				mul_a = ld_q;
				mul_b = rd_q;
			end
		endcase
	end

	rar_mul #(.W(W)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// signs of the two first products, subtraction flips the second
	always_comb begin
		s1_raw = ln_n_q ^ ((kind_q == rar_pkg::KIND_MUL) ? rn_n_q : rd_n_q);
		case (kind_q)
			rar_pkg::KIND_ADD: s2_raw = rn_n_q ^ ld_n_q;
			rar_pkg::KIND_SUB: s2_raw = !(rn_n_q ^ ld_n_q);
			rar_pkg::KIND_MUL: s2_raw = ld_n_q ^ rd_n_q;
			default:           s2_raw = ld_n_q ^ rn_n_q;
		endcase
	end

	// sign-magnitude sum and selection of numerator and denominator
	always_comb begin
		a_neg  = s1_raw && (p1_q != '0);
		b_neg  = s2_raw && (p2_q != '0);
		sum_ab = p1_q + p2_q;
		d_ab   = {1'b0, p1_q} - {1'b0, p2_q};
		d_ba   = {1'b0, p2_q} - {1'b0, p1_q};
		if (a_neg == b_neg) begin
			add_mag = sum_ab;
			add_neg = a_neg;
		end else if (!d_ab[PW]) begin
			add_mag = d_ab[PW-1:0];
			add_neg = a_neg;
		end else begin
			add_mag = d_ba[PW-1:0];
			add_neg = b_neg;
		end
		if (kind_q == rar_pkg::KIND_ADD || kind_q == rar_pkg::KIND_SUB) begin
			num_mag = add_mag;
			num_neg = add_neg;
			den_mag = mul_p;
			den_neg = ld_n_q ^ rd_n_q;
		end else begin
			num_mag = p1_q;
			num_neg = a_neg;
			den_mag = p2_q;
			den_neg = s2_raw;
		end
	end

	assign red_start = (state_q == S_ADD) && (num_mag != '0);

	rar_reduce #(.PW(PW)) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_start),
		.num_in  (num_mag),
		.den_in  (den_mag),
		.num_out (red_num),
		.den_out (red_den),
		.stat    (red_stat)
	);

	// result fields, wrapped to their widths
	always_comb begin
		nmag_ext = EW'(red_num);
		dmag_ext = EW'(red_den);
		nval_ext = neg_q ? (EW'(0) - nmag_ext) : nmag_ext;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= in_err ? S_OUT : S_M1;
					end
				end
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_ADD;
				S_ADD: state_q <= (num_mag == '0) ? S_OUT : S_RED;
				S_RED: begin
					if (red_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					kind_q    <= s_tuser;
					ln_q      <= mag_of(ln_raw);
					ld_q      <= mag_of(ld_raw);
					rn_q      <= mag_of(rn_raw);
					rd_q      <= mag_of(rd_raw);
					ln_n_q    <= ln_raw[W-1];
					ld_n_q    <= ld_raw[W-1];
					rn_n_q    <= rn_raw[W-1];
					rd_n_q    <= rd_raw[W-1];
					m_tdata_q <= '0;
					m_tuser_q <= 1'b1;
				end
			end
			S_M2: p1_q <= mul_p;
			S_M3: p2_q <= mul_p;
			S_ADD: begin
				neg_q     <= num_neg ^ den_neg;
				m_tdata_q <= {rar_pkg::DEN_W'(1), rar_pkg::NUM_W'(0)};
				m_tuser_q <= 1'b0;
			end
			S_RED: begin
				if (red_stat.done) begin
					m_tdata_q <= {dmag_ext[rar_pkg::DEN_W-1:0], nval_ext[rar_pkg::NUM_W-1:0]};
					m_tuser_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`RAR_ASSERT(a_one_item, !(s_tready && m_tvalid), "input ready while a result waits")
	`RAR_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser, m_tdata == '0, "error item has nonzero data")
	`RAR_ASSERT_IMP(a_red_busy, red_stat.busy, state_q == S_RED, "reduction busy outside its state")
	`RAR_ASSERT_NXT(a_done_out, red_stat.done, m_tvalid, "reduced result not presented")

endmodule

FILE: verif/rar_result_check.sv
// result checker for the rational arithmetic block: predicts each reduced fraction and compares
// depends on rar_pkg; instantiated beside the block by rational_arith_reduce_tb
module rar_result_check #(
	parameter int OPERAND_W = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	// left_num, left_den, right_num, right_den from the lowest bit up
	input  logic [((4*OPERAND_W+7)/8)*8-1:0]   s_tdata,
	// kind
	input  rar_pkg::kind_t                     s_tuser,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// result_num, result_den from the lowest bit up
	input  logic [rar_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// zero_den_error
	input  logic                               m_tuser,
	output int                                 fail_count,
	output int                                 expected_left,
	output int                                 results_checked
);

	typedef logic signed [OPERAND_W-1:0] operand_t;

	typedef struct {
		logic signed [rar_pkg::NUM_W-1:0] num;
		logic [rar_pkg::DEN_W-1:0]        den;
		logic                             err;
	} fraction_t;

	// reduced fractions still owed by the block, oldest first
	fraction_t reduced_q[$];

	// result fields as seen on the output
	logic signed [rar_pkg::NUM_W-1:0] got_num;
	logic [rar_pkg::DEN_W-1:0]        got_den;

	assign got_num = m_tdata[rar_pkg::NUM_W-1:0];
	assign got_den = m_tdata[rar_pkg::NUM_W+rar_pkg::DEN_W-1:rar_pkg::NUM_W];

	// exact cross-multiplied result brought to lowest terms, sign on the numerator
	function automatic fraction_t reduce_fraction(rar_pkg::kind_t kind, operand_t ln,
			operand_t ld, operand_t rn, operand_t rd);
		longint    a_n, a_d, b_n, b_d;
		longint    num, den, g, h, t;
		fraction_t r;
		a_n = ln;
		a_d = ld;
		b_n = rn;
		b_d = rd;
		r.num = '0;
		r.den = '0;
		r.err = 1'b1;
		// zero denominator on either side, or dividing by a zero fraction
		if (a_d == 0 || b_d == 0 || (kind == rar_pkg::KIND_DIV && b_n == 0))
			return r;
		case (kind)
			rar_pkg::KIND_ADD: begin
				num = a_n * b_d + b_n * a_d;
				den = a_d * b_d;
			end
			rar_pkg::KIND_SUB: begin
				num = a_n * b_d - b_n * a_d;
				den = a_d * b_d;
			end
			rar_pkg::KIND_MUL: begin
				num = a_n * b_n;
				den = a_d * b_d;
			end
			default: begin
				num = a_n * b_d;
				den = a_d * b_n;
			end
		endcase
		r.err = 1'b0;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		// a zero numerator always reads as 0 over 1
		if (num == 0) begin
			r.num = '0;
			r.den = 1;
			return r;
		end
		// euclid on the magnitudes
		g = (num < 0) ? -num : num;
		h = den;
		while (h != 0) begin
			t = g % h;
			g = h;
			h = t;
		end
		num = num / g;
		den = den / g;
		r.num = num[rar_pkg::NUM_W-1:0];
		r.den = den[rar_pkg::DEN_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// watch both channels: compare each result, then queue the prediction for a new item
	always @(posedge clk or negedge arst_n) begin : watch_channels
		fraction_t want;
		if (!arst_n) begin
			reduced_q.delete();
			expected_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reduced_q.size() == 0) begin
					report_mismatch("result with nothing outstanding", got_num, 0);
				end else begin
					want = reduced_q.pop_front();
					results_checked++;
					if (got_num !== want.num)
						report_mismatch("result_num", got_num, want.num);
					if (got_den !== want.den)
						report_mismatch("result_den", got_den, want.den);
					if (m_tuser !== want.err)
						report_mismatch("zero_den_error", m_tuser, want.err);
				end
			end
			if (s_tvalid && s_tready)
				reduced_q.push_back(reduce_fraction(s_tuser,
					s_tdata[0*OPERAND_W +: OPERAND_W], s_tdata[1*OPERAND_W +: OPERAND_W],
					s_tdata[2*OPERAND_W +: OPERAND_W], s_tdata[3*OPERAND_W +: OPERAND_W]));
			expected_left = reduced_q.size();
		end
	end

endmodule

FILE: verif/rational_arith_reduce_tb.sv
// testbench top for the rational arithmetic block: clock, reset, item stimulus and verdict
// depends on rar_pkg, rational_arith_reduce and rar_result_check
module rational_arith_reduce_tb;

	localparam int OPERAND_W       = 16;
	localparam int IN_TDATA_W      = ((4*OPERAND_W+7)/8)*8;
	localparam int RANDOM_ITEMS    = 2000;
	localparam int STALL_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 200;

	typedef logic signed [OPERAND_W-1:0] operand_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [IN_TDATA_W-1:0]           s_tdata;
	rar_pkg::kind_t                  s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [rar_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            m_tuser;

	int fail_count;
	int expected_left;
	int results_checked;
	int kind_count[4];
	int zero_den_items;
	int hold_offs;

	rational_arith_reduce #(
		.OPERAND_WIDTH(OPERAND_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	rar_result_check #(
		.OPERAND_W(OPERAND_W)
	) result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.fail_count      (fail_count),
		.expected_left   (expected_left),
		.results_checked (results_checked)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one item and hold it until the block takes it
	task automatic offer_item(rar_pkg::kind_t k, operand_t ln, operand_t ld, operand_t rn,
			operand_t rd);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {rd, rn, ld, ln};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		kind_count[k]++;
		if (ld == 0 || rd == 0 || (k == rar_pkg::KIND_DIV && rn == 0))
			zero_den_items++;
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// operand mix: edge values, small values that share factors, and full-range noise
	function automatic operand_t random_operand();
		case ($urandom_range(0, 9))
			0, 1: begin
				case ($urandom_range(0, 5))
					0: return -32768;
					1: return -32767;
					2: return -1;
					3: return 0;
					4: return 1;
					default: return 32767;
				endcase
			end
			2, 3, 4: return operand_t'(int'($urandom_range(0, 40)) - 20);
			default: return operand_t'($urandom);
		endcase
	endfunction

	// receiver: ready pattern changes mode now and then, with long hold-offs mid-run
	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		int cycle_no;
		m_tready = 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		cycle_no = 0;
		hold_offs = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cycle_no++;
			if (cycle_no == 20000 || cycle_no == 90000) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_offs++;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
			STALL_LIMIT, expected_left);
		$display("Test completed with failures");
		$finish;
	end

	// reset, directed items, random bursts, drain and verdict
	initial begin : stimulus
		int             sent;
		int             burst;
		rar_pkg::kind_t k;
		operand_t       ln, ld, rn, rd;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = rar_pkg::KIND_ADD;
		arst_n   = 1'b0;
		zero_den_items = 0;
		foreach (kind_count[i])
			kind_count[i] = 0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// simple cases of each operation
		offer_item(rar_pkg::KIND_ADD, 1, 2, 1, 3);
		offer_item(rar_pkg::KIND_SUB, 1, 2, 1, 2);
		offer_item(rar_pkg::KIND_MUL, 2, 3, 3, 4);
		offer_item(rar_pkg::KIND_DIV, 2, 3, 4, 9);
		// extremes: numerator magnitude up to two to the 31st before reduction
		offer_item(rar_pkg::KIND_ADD, -32768, -32768, -32768, -32768);
		offer_item(rar_pkg::KIND_SUB, -32768, -32768, 32767, 32767);
		offer_item(rar_pkg::KIND_SUB, 32767, -32768, -32768, 32767);
		offer_item(rar_pkg::KIND_MUL, -32768, 1, -32768, 1);
		offer_item(rar_pkg::KIND_DIV, -32768, 1, 1, -32768);
		offer_item(rar_pkg::KIND_DIV, 32767, -1, -32768, 32767);
		offer_item(rar_pkg::KIND_MUL, 32767, 32767, 32767, 32767);
		offer_item(rar_pkg::KIND_ADD, 32767, 1, 32767, 1);
		offer_item(rar_pkg::KIND_SUB, -32768, 1, 32767, 1);
		// zero numerators give 0 over 1
		offer_item(rar_pkg::KIND_ADD, 0, 5, 0, -7);
		offer_item(rar_pkg::KIND_DIV, 0, 7, 3, -5);
		// zero denominators and division by zero
		offer_item(rar_pkg::KIND_ADD, 1, 0, 1, 1);
		offer_item(rar_pkg::KIND_MUL, 1, 1, 1, 0);
		offer_item(rar_pkg::KIND_SUB, 0, 0, 0, 0);
		offer_item(rar_pkg::KIND_DIV, 3, 4, 0, 5);
		// negative denominators and large coprime parts
		offer_item(rar_pkg::KIND_ADD, 1, -3, 1, -6);
		offer_item(rar_pkg::KIND_SUB, -1, -1, -1, -1);
		offer_item(rar_pkg::KIND_DIV, -1, -1, -1, -1);
		offer_item(rar_pkg::KIND_ADD, -1, 32767, 1, 32766);
		offer_item(rar_pkg::KIND_MUL, 32767, 32766, 32765, 32763);

		// random bursts with random gaps
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				k  = rar_pkg::kind_t'($urandom_range(0, 3));
				ln = random_operand();
				ld = random_operand();
				rn = random_operand();
				rd = random_operand();
				if ($urandom_range(0, 19) == 0) begin
					case ($urandom_range(0, 2))
						0: ld = 0;
						1: rd = 0;
						default: begin
							k  = rar_pkg::KIND_DIV;
							rn = 0;
						end
					endcase
				end
				offer_item(k, ln, ld, rn, rd);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 8));
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain
		while (expected_left != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);

		$display("covered %0d items: add %0d, subtract %0d, multiply %0d, divide %0d;",
			kind_count[rar_pkg::KIND_ADD] + kind_count[rar_pkg::KIND_SUB]
				+ kind_count[rar_pkg::KIND_MUL] + kind_count[rar_pkg::KIND_DIV],
			kind_count[rar_pkg::KIND_ADD], kind_count[rar_pkg::KIND_SUB],
			kind_count[rar_pkg::KIND_MUL], kind_count[rar_pkg::KIND_DIV]);
		$display("%0d with a zero denominator; checked %0d results; receiver held off %0d %s",
			zero_den_items, results_checked, hold_offs, "times");
		$display("for %0d cycles each, %0d mismatches", HOLD_OFF_CYCLES, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: rational_arith_reduce.f
+incdir+rtl
rtl/rar_pkg.sv
rtl/rar_mul.sv
rtl/rar_sub.sv
rtl/rar_reduce.sv
rtl/rational_arith_reduce.sv
verif/rar_result_check.sv
verif/rational_arith_reduce_tb.sv
